@@ design/sts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, character codes and classification helpers for the script
// token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int LENGTH_BITS_DEF   = 16;
    localparam int POSITION_BITS_DEF = 32;

    // fixed widths of the result fields on the port
    localparam int TOKEN_LEN_W = 16;
    localparam int TOKEN_POS_W = 32;
    localparam int KIND_W      = 5;

    // result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    typedef enum logic [KIND_W-1:0] {
        K_IF      = 5'd0,
        K_THEN    = 5'd1,
        K_ELSE    = 5'd2,
        K_ENDIF   = 5'd3,
        K_AND     = 5'd4,
        K_OR      = 5'd5,
        K_EQ      = 5'd6,
        K_NE      = 5'd7,
        K_NOT     = 5'd8,
        K_LPAREN  = 5'd9,
        K_RPAREN  = 5'd10,
        K_SEMI    = 5'd11,
        K_COMMA   = 5'd12,
        K_CONCAT  = 5'd13,
        K_NEWLINE = 5'd14,
        K_SPACE   = 5'd15,
        K_COMMENT = 5'd16,
        K_WORD    = 5'd17,
        K_QUOTED  = 5'd18,
        K_UNKNOWN = 5'd19,
        K_UNTERM  = 5'd20
    } kind_t;

    typedef enum logic [18:0] {
        MODE_IDLE    = 19'h00001,
        MODE_WORD    = 19'h00002,
        MODE_SPACE   = 19'h00004,
        MODE_COMMENT = 19'h00008,
        MODE_QUOTE   = 19'h00010,
        MODE_AMP     = 19'h00020,
        MODE_BAR     = 19'h00040,
        MODE_EQ      = 19'h00080,
        MODE_BANG    = 19'h00100,
        MODE_I       = 19'h00200,
        MODE_T       = 19'h00400,
        MODE_TH      = 19'h00800,
        MODE_THE     = 19'h01000,
        MODE_E       = 19'h02000,
        MODE_EL      = 19'h04000,
        MODE_ELS     = 19'h08000,
        MODE_EN      = 19'h10000,
        MODE_END     = 19'h20000,
        MODE_ENDI    = 19'h40000
    } mode_t;

    typedef struct packed {
        logic                   final_token;
        logic [TOKEN_POS_W-1:0] token_start;
        logic [TOKEN_LEN_W-1:0] token_length;
        kind_t                  token_kind;
    } token_t;

    // up to two tokens produced by one text byte
    typedef struct packed {
        logic [1:0]     count;
        token_t [1:0]   item;
    } push_t;

    localparam logic [7:0] CH_A      = "a";
    localparam logic [7:0] CH_D      = "d";
    localparam logic [7:0] CH_E      = "e";
    localparam logic [7:0] CH_F      = "f";
    localparam logic [7:0] CH_H      = "h";
    localparam logic [7:0] CH_I      = "i";
    localparam logic [7:0] CH_L      = "l";
    localparam logic [7:0] CH_N      = "n";
    localparam logic [7:0] CH_S      = "s";
    localparam logic [7:0] CH_T      = "t";
    localparam logic [7:0] CH_AMP    = "&";
    localparam logic [7:0] CH_BAR    = "|";
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_HASH   = "#";
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_COLON  = ":";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_DOT    = ".";

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_UNDER || c == CH_COLON ||
               c == CH_SLASH || c == CH_DOT;
    endfunction

    function automatic logic is_space_char(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

endpackage
`default_nettype wire

@@ design/sts_scan_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sts_scan_unit
// Scanner state and the per-byte step: one text byte in, up to two
// finished tokens out.
// ----------------------------------------------------------------------------
module sts_scan_unit #(
    parameter int LENGTH_BITS   = sts_pkg::LENGTH_BITS_DEF,
    parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    text_byte,
    input  wire logic          last_byte,
    output sts_pkg::push_t     push
);

    localparam int LB = LENGTH_BITS;
    localparam int PB = POSITION_BITS;
    localparam int LW = (LB > sts_pkg::TOKEN_LEN_W) ? LB : sts_pkg::TOKEN_LEN_W;
    localparam int PW = (PB > sts_pkg::TOKEN_POS_W) ? PB : sts_pkg::TOKEN_POS_W;
    localparam logic [LB-1:0] LEN_MAX = '1;
    localparam logic [LB-1:0] LEN_ONE = LB'(1);
    localparam logic [LB-1:0] LEN_TWO = LB'(2);

    sts_pkg::mode_t  mode_reg,  mode_next;
    logic [LB-1:0]   len_reg,   len_next;
    logic [PB-1:0]   start_reg, start_next;
    logic [PB-1:0]   pos_reg,   pos_next;
    logic            esc_reg,   esc_next;

    function automatic logic [sts_pkg::TOKEN_LEN_W-1:0] len_out(input logic [LB-1:0] v);
        logic [LW-1:0] w;
        w = LW'(v);
        return w[sts_pkg::TOKEN_LEN_W-1:0];
    endfunction

    function automatic logic [sts_pkg::TOKEN_POS_W-1:0] pos_out(input logic [PB-1:0] v);
        logic [PW-1:0] w;
        w = PW'(v);
        return w[sts_pkg::TOKEN_POS_W-1:0];
    endfunction

    // token start decode for the current byte
    sts_pkg::mode_t  st_mode;
    logic            st_emit;
    sts_pkg::kind_t  st_kind;

    always_comb
    begin
        st_mode = sts_pkg::MODE_IDLE;
        st_emit = 1'b0;
        st_kind = sts_pkg::K_UNKNOWN;
        case (text_byte)
            sts_pkg::CH_I:      st_mode = sts_pkg::MODE_I;
            sts_pkg::CH_T:      st_mode = sts_pkg::MODE_T;
            sts_pkg::CH_E:      st_mode = sts_pkg::MODE_E;
            sts_pkg::CH_AMP:    st_mode = sts_pkg::MODE_AMP;
            sts_pkg::CH_BAR:    st_mode = sts_pkg::MODE_BAR;
            sts_pkg::CH_EQ:     st_mode = sts_pkg::MODE_EQ;
            sts_pkg::CH_BANG:   st_mode = sts_pkg::MODE_BANG;
            sts_pkg::CH_HASH:   st_mode = sts_pkg::MODE_COMMENT;
            sts_pkg::CH_QUOTE:  st_mode = sts_pkg::MODE_QUOTE;
            sts_pkg::CH_LPAREN: begin st_emit = 1'b1; st_kind = sts_pkg::K_LPAREN;  end
            sts_pkg::CH_RPAREN: begin st_emit = 1'b1; st_kind = sts_pkg::K_RPAREN;  end
            sts_pkg::CH_SEMI:   begin st_emit = 1'b1; st_kind = sts_pkg::K_SEMI;    end
            sts_pkg::CH_COMMA:  begin st_emit = 1'b1; st_kind = sts_pkg::K_COMMA;   end
            sts_pkg::CH_PLUS:   begin st_emit = 1'b1; st_kind = sts_pkg::K_CONCAT;  end
            sts_pkg::CH_NL:     begin st_emit = 1'b1; st_kind = sts_pkg::K_NEWLINE; end
            default:
            begin
                if (sts_pkg::is_space_char(text_byte))
                    st_mode = sts_pkg::MODE_SPACE;
                else if (sts_pkg::is_word_char(text_byte))
                    st_mode = sts_pkg::MODE_WORD;
                else
                    st_emit = 1'b1;
            end
        endcase
    end

    // keyword progress: expected byte, follow-on mode, completion kind
    logic [7:0]      kw_want;
    sts_pkg::mode_t  kw_follow;
    logic            kw_done;
    sts_pkg::kind_t  kw_kind;

    always_comb
    begin
        kw_want   = sts_pkg::CH_F;
        kw_follow = sts_pkg::MODE_IDLE;
        kw_done   = 1'b0;
        kw_kind   = sts_pkg::K_ENDIF;
        case (mode_reg)
            sts_pkg::MODE_I:    begin kw_want = sts_pkg::CH_F; kw_done = 1'b1; kw_kind = sts_pkg::K_IF; end
            sts_pkg::MODE_T:    begin kw_want = sts_pkg::CH_H; kw_follow = sts_pkg::MODE_TH;  end
            sts_pkg::MODE_TH:   begin kw_want = sts_pkg::CH_E; kw_follow = sts_pkg::MODE_THE; end
            sts_pkg::MODE_THE:  begin kw_want = sts_pkg::CH_N; kw_done = 1'b1; kw_kind = sts_pkg::K_THEN; end
            sts_pkg::MODE_EL:   begin kw_want = sts_pkg::CH_S; kw_follow = sts_pkg::MODE_ELS; end
            sts_pkg::MODE_ELS:  begin kw_want = sts_pkg::CH_E; kw_done = 1'b1; kw_kind = sts_pkg::K_ELSE; end
            sts_pkg::MODE_EN:   begin kw_want = sts_pkg::CH_D; kw_follow = sts_pkg::MODE_END;  end
            sts_pkg::MODE_END:  begin kw_want = sts_pkg::CH_I; kw_follow = sts_pkg::MODE_ENDI; end
            default:            begin kw_want = sts_pkg::CH_F; kw_done = 1'b1; kw_kind = sts_pkg::K_ENDIF; end
        endcase
    end

    logic [LB-1:0]   len_inc;
    assign len_inc = (len_reg == LEN_MAX) ? len_reg : len_reg + LEN_ONE;

    logic            a_vld;
    sts_pkg::kind_t  a_kind;
    logic [LB-1:0]   a_len;
    logic            do_start;
    sts_pkg::mode_t  mode_mid;
    logic [LB-1:0]   len_mid;
    logic [PB-1:0]   start_mid;
    logic            esc_mid;
    logic            c_vld;
    sts_pkg::kind_t  c_kind;
    logic [LB-1:0]   c_len;
    logic            is_word;
    logic            is_space;

    assign is_word  = sts_pkg::is_word_char(text_byte);
    assign is_space = sts_pkg::is_space_char(text_byte);

    always_comb
    begin
        a_vld     = 1'b0;
        a_kind    = sts_pkg::K_WORD;
        a_len     = len_reg;
        do_start  = 1'b0;
        mode_mid  = mode_reg;
        len_mid   = len_reg;
        start_mid = start_reg;
        esc_mid   = esc_reg;

        case (mode_reg)
            sts_pkg::MODE_IDLE:
                do_start = 1'b1;
            sts_pkg::MODE_WORD:
            begin
                if (is_word)
                    len_mid = len_inc;
                else
                begin
                    a_vld = 1'b1; a_kind = sts_pkg::K_WORD; do_start = 1'b1;
                end
            end
            sts_pkg::MODE_SPACE:
            begin
                if (is_space)
                    len_mid = len_inc;
                else
                begin
                    a_vld = 1'b1; a_kind = sts_pkg::K_SPACE; do_start = 1'b1;
                end
            end
            sts_pkg::MODE_COMMENT:
            begin
                if (text_byte != sts_pkg::CH_NL)
                    len_mid = len_inc;
                else
                begin
                    a_vld = 1'b1; a_kind = sts_pkg::K_COMMENT; do_start = 1'b1;
                end
            end
            sts_pkg::MODE_QUOTE:
            begin
                len_mid = len_inc;
                if (text_byte == sts_pkg::CH_BSLASH || esc_reg)
                    esc_mid = ~esc_reg;
                else if (text_byte == sts_pkg::CH_QUOTE)
                begin
                    a_vld = 1'b1; a_kind = sts_pkg::K_QUOTED; a_len = len_inc;
                    mode_mid = sts_pkg::MODE_IDLE;
                end
            end
            sts_pkg::MODE_AMP, sts_pkg::MODE_BAR, sts_pkg::MODE_EQ:
            begin
                a_vld = 1'b1;
                if ((mode_reg == sts_pkg::MODE_AMP && text_byte == sts_pkg::CH_AMP) ||
                    (mode_reg == sts_pkg::MODE_BAR && text_byte == sts_pkg::CH_BAR) ||
                    (mode_reg == sts_pkg::MODE_EQ  && text_byte == sts_pkg::CH_EQ))
                begin
                    a_len    = LEN_TWO;
                    mode_mid = sts_pkg::MODE_IDLE;
                    a_kind   = (mode_reg == sts_pkg::MODE_AMP) ? sts_pkg::K_AND :
                               (mode_reg == sts_pkg::MODE_BAR) ? sts_pkg::K_OR : sts_pkg::K_EQ;
                end
                else
                begin
                    a_kind = sts_pkg::K_UNKNOWN; a_len = LEN_ONE; do_start = 1'b1;
                end
            end
            sts_pkg::MODE_BANG:
            begin
                a_vld = 1'b1;
                if (text_byte == sts_pkg::CH_EQ)
                begin
                    a_kind = sts_pkg::K_NE; a_len = LEN_TWO; mode_mid = sts_pkg::MODE_IDLE;
                end
                else
                begin
                    a_kind = sts_pkg::K_NOT; a_len = LEN_ONE; do_start = 1'b1;
                end
            end
            default:
            begin
                // keyword prefixes
                if (mode_reg == sts_pkg::MODE_E &&
                    (text_byte == sts_pkg::CH_L || text_byte == sts_pkg::CH_N))
                begin
                    len_mid  = len_inc;
                    mode_mid = (text_byte == sts_pkg::CH_L) ? sts_pkg::MODE_EL
                                                            : sts_pkg::MODE_EN;
                end
                else if (mode_reg != sts_pkg::MODE_E && text_byte == kw_want)
                begin
                    len_mid = len_inc;
                    if (kw_done)
                    begin
                        a_vld = 1'b1; a_kind = kw_kind; a_len = len_inc;
                        mode_mid = sts_pkg::MODE_IDLE;
                    end
                    else
                        mode_mid = kw_follow;
                end
                else if (is_word)
                begin
                    len_mid  = len_inc;
                    mode_mid = sts_pkg::MODE_WORD;
                end
                else
                begin
                    a_vld = 1'b1; a_kind = sts_pkg::K_WORD; do_start = 1'b1;
                end
            end
        endcase

        if (a_vld && !do_start)
            mode_mid = sts_pkg::MODE_IDLE;

        if (do_start)
        begin
            start_mid = pos_reg;
            len_mid   = LEN_ONE;
            esc_mid   = 1'b0;
            mode_mid  = st_emit ? sts_pkg::MODE_IDLE : st_mode;
        end

        // flush of the open token on the final byte
        c_vld  = 1'b0;
        c_kind = sts_pkg::K_WORD;
        c_len  = len_mid;
        if (last_byte)
        begin
            c_vld = 1'b1;
            case (mode_mid)
                sts_pkg::MODE_IDLE:    c_vld  = 1'b0;
                sts_pkg::MODE_SPACE:   c_kind = sts_pkg::K_SPACE;
                sts_pkg::MODE_COMMENT: c_kind = sts_pkg::K_COMMENT;
                sts_pkg::MODE_QUOTE:   c_kind = sts_pkg::K_UNTERM;
                sts_pkg::MODE_AMP, sts_pkg::MODE_BAR, sts_pkg::MODE_EQ:
                begin
                    c_kind = sts_pkg::K_UNKNOWN; c_len = LEN_ONE;
                end
                sts_pkg::MODE_BANG:
                begin
                    c_kind = sts_pkg::K_NOT; c_len = LEN_ONE;
                end
                default:               c_kind = sts_pkg::K_WORD;
            endcase
        end
    end

    // pack the candidate tokens in order into the two push slots
    sts_pkg::token_t [2:0] cand;
    logic [2:0]            cand_vld;

    always_comb
    begin
        cand_vld = {c_vld, do_start && st_emit, a_vld};

        cand[0].final_token  = 1'b0;
        cand[0].token_start  = pos_out(start_reg);
        cand[0].token_length = len_out(a_len);
        cand[0].token_kind   = a_kind;

        cand[1].final_token  = 1'b0;
        cand[1].token_start  = pos_out(pos_reg);
        cand[1].token_length = len_out(LEN_ONE);
        cand[1].token_kind   = st_kind;

        cand[2].final_token  = 1'b0;
        cand[2].token_start  = pos_out(start_mid);
        cand[2].token_length = len_out(c_len);
        cand[2].token_kind   = c_kind;
    end

    always_comb
    begin
        push.count = 2'd0;
        push.item  = {cand[0], cand[0]};
        for (int i = 0; i < 3; i++)
        begin
            if (cand_vld[i] && push.count != 2'd2)
            begin
                push.item[push.count[0]] = cand[i];
                push.count = push.count + 2'd1;
            end
        end
        if (last_byte && push.count != 2'd0)
            push.item[push.count[0] ^ 1'b1].final_token = 1'b1;
        if (!step)
            push.count = 2'd0;
    end

    always_comb
    begin
        if (last_byte)
        begin
            mode_next  = sts_pkg::MODE_IDLE;
            len_next   = '0;
            start_next = '0;
            pos_next   = '0;
            esc_next   = 1'b0;
        end
        else
        begin
            mode_next  = mode_mid;
            len_next   = len_mid;
            start_next = start_mid;
            pos_next   = pos_reg + PB'(1);
            esc_next   = esc_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sts_pkg::MODE_IDLE;
            len_reg   <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
            esc_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            esc_reg   <= esc_next;
        end
    end

endmodule
`default_nettype wire

@@ design/sts_result_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sts_result_fifo
// Four-entry token queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module sts_result_fifo (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sts_pkg::push_t                    push,
    input  wire logic                              pop,
    output sts_pkg::token_t                        head,
    output logic                                   head_vld,
    output logic [sts_pkg::RQ_CNT_W-1:0]           level
);

    sts_pkg::token_t                 entry_reg [sts_pkg::RQ_DEPTH];
    logic [sts_pkg::RQ_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [sts_pkg::RQ_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [sts_pkg::RQ_CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [sts_pkg::RQ_PTR_W-1:0]    wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + sts_pkg::RQ_PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + sts_pkg::RQ_PTR_W'(push.count);
    assign rd_ptr_next  = pop ? rd_ptr_reg + sts_pkg::RQ_PTR_W'(1) : rd_ptr_reg;
    assign cnt_next     = cnt_reg + sts_pkg::RQ_CNT_W'(push.count)
                          - sts_pkg::RQ_CNT_W'(pop);

    assign head     = entry_reg[rd_ptr_reg];
    assign head_vld = (cnt_reg != '0);
    assign level    = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.item[0];
        if (push.count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.item[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ design/script_token_scanner_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// script_token_scanner_core
// Byte-stream script tokenizer: one token transaction per recognized token.
// ----------------------------------------------------------------------------
// Text bytes enter on s_axis, one per cycle while s_axis_tready is high, with
// s_axis_tlast on the final byte of a text; each finished token leaves on
// m_axis as kind, length and start offset, with m_axis_tlast on the last
// token of the text. A byte is registered, stepped through the scanner and
// its tokens (zero, one or two) land in a four-entry result queue. Input
// advances at one byte per cycle whenever the queue has room for two tokens;
// a byte that closes one token and is itself a one-byte token (or closes a
// token at end of text) puts two tokens in the queue, which drains one per
// cycle while m_axis_tready is high. The first token reaches m_axis through
// the input register and the result queue. After a final byte the scanner
// is back in its reset state and the next text starts at offset 0.
// ----------------------------------------------------------------------------
module script_token_scanner_core #(
    parameter int LENGTH_BITS   = sts_pkg::LENGTH_BITS_DEF,
    parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tlast,   // last_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [4:0] token_kind, [20:5] token_length,
                                             // [52:21] token_start, [55:53] zero
    output logic             m_axis_tlast    // final_token
);

    logic        in_vld_reg,  in_vld_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        step;

    sts_pkg::push_t                 push;
    sts_pkg::token_t                head;
    logic                           head_vld;
    logic [sts_pkg::RQ_CNT_W-1:0]   level;

    // room for the worst case of two tokens from one byte
    assign step          = in_vld_reg &&
                           (level <= sts_pkg::RQ_CNT_W'(sts_pkg::RQ_DEPTH - 2));
    assign s_axis_tready = !in_vld_reg || step;
    assign in_vld_next   = s_axis_tready ? s_axis_tvalid : in_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    sts_scan_unit #(
        .LENGTH_BITS   (LENGTH_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .text_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .push      (push)
    );

    sts_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (m_axis_tvalid && m_axis_tready),
        .head     (head),
        .head_vld (head_vld),
        .level    (level)
    );

    assign m_axis_tvalid = head_vld;
    assign m_axis_tdata  = {3'b000, head.token_start, head.token_length, head.token_kind};
    assign m_axis_tlast  = head.final_token;

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for script_token_scanner_core. Texts built from random
// keywords, operators, words, blanks, comments and quoted strings stream into
// s_axis in bursts. Each byte transaction steps a local scanner model whose
// tokens are queued and compared field by field with m_axis transactions. The
// receiver stalls in changing patterns, with long hold-offs now and then.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_BYTES   = 650;
    localparam int HOLD_CYCLES    = 150;
    localparam int HOLD_SPACING   = 250;

    typedef struct packed {
        logic [7:0] text;
        logic       fin;
    } text_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    text_byte_t          script_q[$];     // bytes waiting to be driven
    logic [7:0]          text_buf[$];     // text under construction
    sts_pkg::token_t     tokens_due[$];   // predicted tokens, oldest first
    sts_pkg::token_t     step_tokens[$];

    // scanner model state
    sts_pkg::mode_t scan_mode = sts_pkg::MODE_IDLE;
    logic [15:0] tok_len = '0;
    logic [31:0] tok_start = '0;
    logic [31:0] byte_pos = '0;
    logic        esc = 1'b0;

    logic        in_fire = 1'b0;
    int          bytes_taken = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    string       keyword_set[4] = '{"if", "then", "else", "endif"};
    string       prefix_set[10] = '{"i", "t", "th", "the", "e", "el", "els", "en", "end",
                                    "endi"};
    string       oper_set[8]    = '{"&&", "||", "==", "!=", "!", "&", "|", "="};
    string       punct_set      = "();,+";
    string       word_set       =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_:/.";
    logic [7:0]  blank_set[5]   = '{sts_pkg::CH_SP, sts_pkg::CH_TAB, sts_pkg::CH_VT,
                                    sts_pkg::CH_FF, sts_pkg::CH_CR};

    script_token_scanner_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scanner model
    // ------------------------------------------------------------------
    function automatic logic word_byte(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == sts_pkg::CH_UNDER ||
               c == sts_pkg::CH_COLON || c == sts_pkg::CH_SLASH || c == sts_pkg::CH_DOT;
    endfunction

    function automatic logic blank_byte(logic [7:0] c);
        return c == sts_pkg::CH_SP || c == sts_pkg::CH_TAB || c == sts_pkg::CH_VT ||
               c == sts_pkg::CH_FF || c == sts_pkg::CH_CR;
    endfunction

    function automatic void reset_scanner();
        scan_mode = sts_pkg::MODE_IDLE;
        tok_len   = '0;
        tok_start = '0;
        byte_pos  = '0;
        esc       = 1'b0;
    endfunction

    function automatic void grow_len();
        if (tok_len != 16'hFFFF)
            tok_len++;
    endfunction

    function automatic void put_token(sts_pkg::kind_t k, logic [15:0] len);
        sts_pkg::token_t t;
        t.final_token  = 1'b0;
        t.token_start  = tok_start;
        t.token_length = len;
        t.token_kind   = k;
        step_tokens.insert(step_tokens.size(), t);
        scan_mode = sts_pkg::MODE_IDLE;
    endfunction

    function automatic void begin_token(logic [7:0] b);
        tok_start = byte_pos;
        tok_len   = 16'd1;
        esc       = 1'b0;
        case (b)
            sts_pkg::CH_I:      scan_mode = sts_pkg::MODE_I;
            sts_pkg::CH_T:      scan_mode = sts_pkg::MODE_T;
            sts_pkg::CH_E:      scan_mode = sts_pkg::MODE_E;
            sts_pkg::CH_AMP:    scan_mode = sts_pkg::MODE_AMP;
            sts_pkg::CH_BAR:    scan_mode = sts_pkg::MODE_BAR;
            sts_pkg::CH_EQ:     scan_mode = sts_pkg::MODE_EQ;
            sts_pkg::CH_BANG:   scan_mode = sts_pkg::MODE_BANG;
            sts_pkg::CH_LPAREN: put_token(sts_pkg::K_LPAREN, 16'd1);
            sts_pkg::CH_RPAREN: put_token(sts_pkg::K_RPAREN, 16'd1);
            sts_pkg::CH_SEMI:   put_token(sts_pkg::K_SEMI, 16'd1);
            sts_pkg::CH_COMMA:  put_token(sts_pkg::K_COMMA, 16'd1);
            sts_pkg::CH_PLUS:   put_token(sts_pkg::K_CONCAT, 16'd1);
            sts_pkg::CH_NL:     put_token(sts_pkg::K_NEWLINE, 16'd1);
            sts_pkg::CH_HASH:   scan_mode = sts_pkg::MODE_COMMENT;
            sts_pkg::CH_QUOTE:  scan_mode = sts_pkg::MODE_QUOTE;
            default:
            begin
                if (blank_byte(b))
                    scan_mode = sts_pkg::MODE_SPACE;
                else if (word_byte(b))
                    scan_mode = sts_pkg::MODE_WORD;
                else
                    put_token(sts_pkg::K_UNKNOWN, 16'd1);
            end
        endcase
    endfunction

    // keyword progress: byte that continues it, next mode, kind when complete
    function automatic void keyword_byte(logic [7:0] b);
        logic [7:0]     want;
        sts_pkg::mode_t nxt;
        logic           done;
        sts_pkg::kind_t k;
        want = sts_pkg::CH_F;
        nxt  = sts_pkg::MODE_IDLE;
        done = 1'b0;
        k    = sts_pkg::K_ENDIF;
        case (scan_mode)
            sts_pkg::MODE_I:
            begin
                want = sts_pkg::CH_F; done = 1'b1; k = sts_pkg::K_IF;
            end
            sts_pkg::MODE_T:   begin want = sts_pkg::CH_H; nxt = sts_pkg::MODE_TH;   end
            sts_pkg::MODE_TH:  begin want = sts_pkg::CH_E; nxt = sts_pkg::MODE_THE;  end
            sts_pkg::MODE_THE:
            begin
                want = sts_pkg::CH_N; done = 1'b1; k = sts_pkg::K_THEN;
            end
            sts_pkg::MODE_EL:  begin want = sts_pkg::CH_S; nxt = sts_pkg::MODE_ELS;  end
            sts_pkg::MODE_ELS:
            begin
                want = sts_pkg::CH_E; done = 1'b1; k = sts_pkg::K_ELSE;
            end
            sts_pkg::MODE_EN:  begin want = sts_pkg::CH_D; nxt = sts_pkg::MODE_END;  end
            sts_pkg::MODE_END: begin want = sts_pkg::CH_I; nxt = sts_pkg::MODE_ENDI; end
            default:
            begin
                want = sts_pkg::CH_F; done = 1'b1; k = sts_pkg::K_ENDIF;
            end
        endcase
        if (scan_mode == sts_pkg::MODE_E && (b == sts_pkg::CH_L || b == sts_pkg::CH_N))
        begin
            grow_len();
            scan_mode = (b == sts_pkg::CH_L) ? sts_pkg::MODE_EL : sts_pkg::MODE_EN;
        end
        else if (scan_mode != sts_pkg::MODE_E && b == want)
        begin
            grow_len();
            if (done)
                put_token(k, tok_len);
            else
                scan_mode = nxt;
        end
        else if (word_byte(b))
        begin
            grow_len();
            scan_mode = sts_pkg::MODE_WORD;
        end
        else
        begin
            put_token(sts_pkg::K_WORD, tok_len);
            begin_token(b);
        end
    endfunction

    function automatic void scan_byte(logic [7:0] b, logic fin);
        logic [7:0]      pair;
        sts_pkg::kind_t  pair_kind;
        sts_pkg::token_t t;
        step_tokens.delete();
        case (scan_mode)
            sts_pkg::MODE_IDLE:
                begin_token(b);
            sts_pkg::MODE_WORD:
                if (word_byte(b))
                    grow_len();
                else
                begin
                    put_token(sts_pkg::K_WORD, tok_len);
                    begin_token(b);
                end
            sts_pkg::MODE_SPACE:
                if (blank_byte(b))
                    grow_len();
                else
                begin
                    put_token(sts_pkg::K_SPACE, tok_len);
                    begin_token(b);
                end
            sts_pkg::MODE_COMMENT:
                if (b != sts_pkg::CH_NL)
                    grow_len();
                else
                begin
                    put_token(sts_pkg::K_COMMENT, tok_len);
                    begin_token(b);
                end
            sts_pkg::MODE_QUOTE:
            begin
                grow_len();
                if (b == sts_pkg::CH_BSLASH || esc)
                    esc = ~esc;
                else if (b == sts_pkg::CH_QUOTE)
                    put_token(sts_pkg::K_QUOTED, tok_len);
            end
            sts_pkg::MODE_AMP, sts_pkg::MODE_BAR, sts_pkg::MODE_EQ:
            begin
                if (scan_mode == sts_pkg::MODE_AMP)
                begin
                    pair = sts_pkg::CH_AMP;
                    pair_kind = sts_pkg::K_AND;
                end
                else if (scan_mode == sts_pkg::MODE_BAR)
                begin
                    pair = sts_pkg::CH_BAR;
                    pair_kind = sts_pkg::K_OR;
                end
                else
                begin
                    pair = sts_pkg::CH_EQ;
                    pair_kind = sts_pkg::K_EQ;
                end
                if (b == pair)
                    put_token(pair_kind, 16'd2);
                else
                begin
                    put_token(sts_pkg::K_UNKNOWN, 16'd1);
                    begin_token(b);
                end
            end
            sts_pkg::MODE_BANG:
                if (b == sts_pkg::CH_EQ)
                    put_token(sts_pkg::K_NE, 16'd2);
                else
                begin
                    put_token(sts_pkg::K_NOT, 16'd1);
                    begin_token(b);
                end
            default:
                keyword_byte(b);
        endcase

        if (fin)
        begin
            // flush whatever token is still open
            case (scan_mode)
                sts_pkg::MODE_IDLE:    ;
                sts_pkg::MODE_SPACE:   put_token(sts_pkg::K_SPACE, tok_len);
                sts_pkg::MODE_COMMENT: put_token(sts_pkg::K_COMMENT, tok_len);
                sts_pkg::MODE_QUOTE:   put_token(sts_pkg::K_UNTERM, tok_len);
                sts_pkg::MODE_AMP, sts_pkg::MODE_BAR, sts_pkg::MODE_EQ:
                    put_token(sts_pkg::K_UNKNOWN, 16'd1);
                sts_pkg::MODE_BANG:    put_token(sts_pkg::K_NOT, 16'd1);
                default:               put_token(sts_pkg::K_WORD, tok_len);
            endcase
            if (step_tokens.size() != 0)
            begin
                t = step_tokens.pop_back();
                t.final_token = 1'b1;
                step_tokens.insert(step_tokens.size(), t);
            end
            reset_scanner();
        end
        else
            byte_pos++;

        foreach (step_tokens[i])
            tokens_due.insert(tokens_due.size(), step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // text construction
    // ------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    function automatic void end_text();
        text_byte_t tb;
        foreach (text_buf[i])
        begin
            tb.text = text_buf[i];
            tb.fin  = (i == text_buf.size() - 1);
            script_q.insert(script_q.size(), tb);
        end
        text_buf.delete();
    endfunction

    function automatic void add_string(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic logic [7:0] any_but_newline();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == sts_pkg::CH_NL) ? sts_pkg::CH_SP : c;
    endfunction

    function automatic void add_fragment();
        int n;
        n = $urandom_range(1, 8);
        case ($urandom_range(0, 15))
            0:       add_string(keyword_set[$urandom_range(0, 3)]);
            1:       add_string(prefix_set[$urandom_range(0, 9)]);
            2, 3:    add_string(oper_set[$urandom_range(0, 7)]);
            4:       add_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
            5:       add_byte(sts_pkg::CH_NL);
            6, 7:
                for (int i = 0; i < n / 2 + 1; i++)
                    add_byte(blank_set[$urandom_range(0, 4)]);
            8, 9:
                for (int i = 0; i < n; i++)
                    add_byte(word_set[$urandom_range(0, word_set.len() - 1)]);
            10:
            begin
                add_byte(sts_pkg::CH_HASH);
                for (int i = 1; i < n; i++)
                    add_byte(any_but_newline());
                if ($urandom_range(0, 1))
                    add_byte(sts_pkg::CH_NL);
            end
            11, 12:
            begin
                add_byte(sts_pkg::CH_QUOTE);
                for (int i = 1; i < n; i++)
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            add_byte(sts_pkg::CH_BSLASH);
                            add_byte(8'($urandom_range(0, 255)));
                        end
                        1:       add_byte(8'($urandom_range(128, 255)));
                        default: add_byte(word_set[$urandom_range(0, 25)]);
                    endcase
                // now and then the quote stays open
                if ($urandom_range(0, 7) != 0)
                    add_byte(sts_pkg::CH_QUOTE);
            end
            13:      add_byte(8'($urandom_range(128, 255)));
            default: add_byte(8'($urandom_range(0, 255)));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin : drive
        text_byte_t tb;
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (script_q.size() != 0)
            begin
                tb = script_q.pop_front();
                s_axis_tdata  <= tb.text;
                s_axis_tlast  <= tb.fin;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall style picked at random, with long hold-offs
    // ------------------------------------------------------------------
    int rx_style = 0;
    int style_left = 0;
    int hold_left = 0;
    int next_hold_at = 50;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (bytes_taken >= next_hold_at)
            begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + HOLD_SPACING;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    rx_style   = $urandom_range(0, 2);
                    style_left = $urandom_range(8, 64);
                end
                else
                    style_left--;
                case (rx_style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on byte transactions, check token transactions
    // ------------------------------------------------------------------
    task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : monitor
        sts_pkg::token_t want;
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            scan_byte(s_axis_tdata, s_axis_tlast);
            bytes_taken <= bytes_taken + 1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (tokens_due.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: token expected none, got tdata %h tlast %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = tokens_due.pop_front();
                if (m_axis_tdata[4:0] !== want.token_kind)
                    report_field("token_kind", 32'(want.token_kind),
                                 32'(m_axis_tdata[4:0]));
                if (m_axis_tdata[20:5] !== want.token_length)
                    report_field("token_length", 32'(want.token_length),
                                 32'(m_axis_tdata[20:5]));
                if (m_axis_tdata[52:21] !== want.token_start)
                    report_field("token_start", want.token_start, m_axis_tdata[52:21]);
                if (m_axis_tlast !== want.final_token)
                    report_field("final_token", 32'(want.final_token), 32'(m_axis_tlast));
            end
        end
    end

    // cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : run
        int target;
        reset_scanner();

        // every operator and keyword back to back
        add_string("if(then)else;endif,&&||==!=!+");
        end_text();
        // broken keyword prefixes, lone operator bytes, byte extremes, blanks, a comment and an escaped quote
        add_string("iffy endix&|=!");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(sts_pkg::CH_TAB);
        add_byte(sts_pkg::CH_VT);
        add_byte(sts_pkg::CH_FF);
        add_byte(sts_pkg::CH_CR);
        add_string("#c");
        add_byte(sts_pkg::CH_NL);
        add_string("\"a\\\"b\"");
        end_text();
        // quote left open with the escape flag set
        add_string("\"q\\");
        end_text();
        // final byte closes a word and leaves a lone '=' to flush
        add_string("endi=");
        end_text();

        target = script_q.size() + RANDOM_BYTES;
        while (script_q.size() < target)
        begin
            repeat ($urandom_range(1, 10))
                add_fragment();
            end_text();
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (script_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (tokens_due.size() != 0)
        begin
            mismatches++;
            $display("%0t ns: %0d expected tokens never arrived", $time, tokens_due.size());
        end
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
